/* hdl/firmware_push_burst_ack_master_top_macros.svh */
// Assertion macros used by the checker file of the image push master.
// Depends on nothing; included by bare file name.
`ifndef FIRMWARE_PUSH_BURST_ACK_MASTER_TOP_MACROS_SVH
`define FIRMWARE_PUSH_BURST_ACK_MASTER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FPB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fpb assertion failed");

// Next-cycle implication, disabled during reset.
`define FPB_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fpb assertion failed");

`endif

/* hdl/fpb_pkg.sv */
// Package of the image push master: constants, codes and shared types.
// Used by every module of the block; depends on nothing.
package fpb_pkg;

   localparam int BURST   = 16;
   localparam int PAYLOAD = 64;

   localparam int FRAMES_W = $clog2(BURST + 1);
   localparam int BYTES_W  = 21;
   localparam int SIZE_W   = 20;
   localparam int SEQ_W    = 16;
   localparam int ELAP_W   = 17;
   localparam int TMO_W    = 16;
   localparam int RETRY_W  = 4;
   localparam int ID_W     = 8;
   localparam int VALID_W  = 7;
   localparam int DATA_W   = 32;
   localparam int ADDR_W   = 5;

   localparam logic [ELAP_W-1:0] ELAPSED_MAX = 17'h1FFFF;
   localparam logic [ID_W-1:0]   ID_NONE     = 8'hFF;
   localparam logic [RETRY_W-1:0] RETRY_SAT  = 4'hF;

   localparam logic [TMO_W-1:0]   PREPARE_TMO_RST = 16'd5000;
   localparam logic [TMO_W-1:0]   BURST_TMO_RST   = 16'd500;
   localparam logic [TMO_W-1:0]   VERIFY_TMO_RST  = 16'd5000;
   localparam logic [TMO_W-1:0]   BOOT_TMO_RST    = 16'd10000;
   localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 4'd3;
   localparam logic [ID_W-1:0]    BCAST_ID_RST    = 8'd255;

   localparam logic [2:0] REG_PREPARE_TMO = 3'd0;
   localparam logic [2:0] REG_BURST_TMO   = 3'd1;
   localparam logic [2:0] REG_VERIFY_TMO  = 3'd2;
   localparam logic [2:0] REG_BOOT_TMO    = 3'd3;
   localparam logic [2:0] REG_RETRY_LIMIT = 3'd4;
   localparam logic [2:0] REG_BCAST_ID    = 3'd5;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_ABORT = 2'd1;
   localparam logic [1:0] OP_RESP  = 2'd2;
   localparam logic [1:0] OP_TICK  = 2'd3;

   localparam logic [1:0] RESP_ACK     = 2'd0;
   localparam logic [1:0] RESP_VERIFY  = 2'd1;
   localparam logic [1:0] RESP_BOOT_OK = 2'd2;

   localparam logic [2:0] ACT_NONE     = 3'd0;
   localparam logic [2:0] ACT_PREPARE  = 3'd1;
   localparam logic [2:0] ACT_HEADER   = 3'd2;
   localparam logic [2:0] ACT_DATA     = 3'd3;
   localparam logic [2:0] ACT_VERIFY   = 3'd4;
   localparam logic [2:0] ACT_ACTIVATE = 3'd5;
   localparam logic [2:0] ACT_ABORT    = 3'd6;

   localparam logic [2:0] PH_IDLE     = 3'd0;
   localparam logic [2:0] PH_PREPARE  = 3'd1;
   localparam logic [2:0] PH_HEADER   = 3'd2;
   localparam logic [2:0] PH_DATA     = 3'd3;
   localparam logic [2:0] PH_VERIFY   = 3'd4;
   localparam logic [2:0] PH_ACTIVATE = 3'd5;
   localparam logic [2:0] PH_DONE     = 3'd6;
   localparam logic [2:0] PH_FAILED   = 3'd7;

   localparam logic [2:0] ERR_NONE   = 3'd0;
   localparam logic [2:0] ERR_NOIMG  = 3'd1;
   localparam logic [2:0] ERR_NAK    = 3'd2;
   localparam logic [2:0] ERR_TMO    = 3'd3;
   localparam logic [2:0] ERR_RETRY  = 3'd4;
   localparam logic [2:0] ERR_VERIFY = 3'd5;

   localparam logic [1:0] REPLY_OK       = 2'd0;
   localparam logic [1:0] REPLY_BUSY     = 2'd1;
   localparam logic [1:0] REPLY_NOIMG    = 2'd2;
   localparam logic [1:0] REPLY_NO_START = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EVAL,
      ST_BURST
   } ctrl_state_type;

   typedef struct packed {
      logic load_en;
      logic eval_en;
      logic burst_en;
   } dp_cmd_type;

   typedef struct packed {
      logic burst_go;
      logic burst_last;
   } dp_status_type;

   typedef struct packed {
      logic [TMO_W-1:0]   prepare_tmo;
      logic [TMO_W-1:0]   burst_tmo;
      logic [TMO_W-1:0]   verify_tmo;
      logic [TMO_W-1:0]   boot_tmo;
      logic [RETRY_W-1:0] retry_limit;
      logic [ID_W-1:0]    bcast_id;
   } cfg_type;

endpackage

/* hdl/fpb_csr.sv */
// Configuration registers of the image push master behind an APB-style port.
// Depends on fpb_pkg for widths, register indexes and reset values.
module fpb_csr
   import fpb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign pready  = 1'b1;
   assign reg_idx = paddr[ADDR_W-1:2];
   assign wr_en   = psel & penable & pwrite;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_PREPARE_TMO: cfg_in.prepare_tmo = pwdata[TMO_W-1:0];
            REG_BURST_TMO:   cfg_in.burst_tmo   = pwdata[TMO_W-1:0];
            REG_VERIFY_TMO:  cfg_in.verify_tmo  = pwdata[TMO_W-1:0];
            REG_BOOT_TMO:    cfg_in.boot_tmo    = pwdata[TMO_W-1:0];
            REG_RETRY_LIMIT: cfg_in.retry_limit = pwdata[RETRY_W-1:0];
            REG_BCAST_ID:    cfg_in.bcast_id    = pwdata[ID_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PREPARE_TMO: prdata = DATA_W'(cfg_ff.prepare_tmo);
         REG_BURST_TMO:   prdata = DATA_W'(cfg_ff.burst_tmo);
         REG_VERIFY_TMO:  prdata = DATA_W'(cfg_ff.verify_tmo);
         REG_BOOT_TMO:    prdata = DATA_W'(cfg_ff.boot_tmo);
         REG_RETRY_LIMIT: prdata = DATA_W'(cfg_ff.retry_limit);
         REG_BCAST_ID:    prdata = DATA_W'(cfg_ff.bcast_id);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prepare_tmo <= PREPARE_TMO_RST;
         cfg_ff.burst_tmo   <= BURST_TMO_RST;
         cfg_ff.verify_tmo  <= VERIFY_TMO_RST;
         cfg_ff.boot_tmo    <= BOOT_TMO_RST;
         cfg_ff.retry_limit <= RETRY_LIMIT_RST;
         cfg_ff.bcast_id    <= BCAST_ID_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* hdl/fpb_ctrl.sv */
// Controller of the image push master: accepts a transaction, runs one
// evaluation step and, if due, the burst sequencer. Depends on fpb_pkg.
module fpb_ctrl
   import fpb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          busy
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd.load_en  = 1'b0;
      cmd.eval_en  = 1'b0;
      cmd.burst_en = 1'b0;
      busy         = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load_en = 1'b1;
               state_in    = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cmd.eval_en = 1'b1;
            state_in    = status.burst_go ? ST_BURST : ST_IDLE;
         end
         ST_BURST: begin
            cmd.burst_en = 1'b1;
            if (status.burst_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* hdl/fpb_dp.sv */
// Datapath of the image push master: transfer state, event evaluation,
// frame generation and the result registers. Depends on fpb_pkg.
module fpb_dp
   import fpb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  dp_cmd_type         cmd,
   output dp_status_type      status,
   input  cfg_type            cfg,
   input  logic [1:0]         req_op,
   input  logic [ID_W-1:0]    req_board_id,
   input  logic [SIZE_W-1:0]  req_image_size,
   input  logic               req_image_ready,
   input  logic [1:0]         req_resp_code,
   input  logic [ID_W-1:0]    req_resp_board,
   output logic               rsp_strobe,
   output logic [2:0]         rsp_action,
   output logic [SIZE_W-1:0]  rsp_frame_offset,
   output logic [VALID_W-1:0] rsp_valid_bytes,
   output logic [SEQ_W-1:0]   rsp_frame_seq,
   output logic [ID_W-1:0]    rsp_target,
   output logic [2:0]         rsp_phase,
   output logic [2:0]         rsp_error_code,
   output logic [1:0]         rsp_start_reply,
   output logic               rsp_last
);

   localparam logic [BYTES_W-1:0] BACK_FULL = BYTES_W'(BURST * PAYLOAD);
   localparam logic [BYTES_W-1:0] PAY_B     = BYTES_W'(PAYLOAD);

   logic [1:0]         op_ff;
   logic [ID_W-1:0]    board_ff;
   logic [SIZE_W-1:0]  isize_ff;
   logic               iready_ff;
   logic [1:0]         code_ff;
   logic [ID_W-1:0]    rboard_ff;

   logic [2:0]          phase_ff, phase_in;
   logic [2:0]          error_ff, error_in;
   logic [ID_W-1:0]     target_ff, target_in;
   logic [SIZE_W-1:0]   size_ff, size_in;
   logic [BYTES_W-1:0]  bytes_ff, bytes_in;
   logic [SEQ_W-1:0]    seq_ff, seq_in;
   logic [SEQ_W-1:0]    bstart_ff, bstart_in;
   logic [FRAMES_W-1:0] bframes_ff, bframes_in;
   logic [RETRY_W-1:0]  retry_ff, retry_in;
   logic [ELAP_W-1:0]   elapsed_ff, elapsed_in;
   logic [1:0]          reply_ff, reply_in;

   logic               strobe_ff, strobe_in;
   logic [2:0]         act_ff, act_in;
   logic [SIZE_W-1:0]  off_ff, off_in;
   logic [VALID_W-1:0] valid_ff, valid_in;
   logic [SEQ_W-1:0]   oseq_ff, oseq_in;
   logic [ID_W-1:0]    otgt_ff, otgt_in;
   logic [2:0]         ophase_ff, ophase_in;
   logic [2:0]         oerr_ff, oerr_in;
   logic [1:0]         orep_ff, orep_in;
   logic               olast_ff, olast_in;

   always_comb begin
      logic               have;
      logic               want_burst;
      logic [2:0]         cmd_act;
      logic [ELAP_W-1:0]  elap_eff;
      logic [RETRY_W:0]   n_retry;
      logic [BYTES_W-1:0] back;
      logic [BYTES_W-1:0] rem;
      logic [BYTES_W-1:0] bytes_nx;
      logic               frame_last;

      have       = 1'b0;
      want_burst = 1'b0;
      cmd_act    = ACT_NONE;
      elap_eff   = elapsed_ff;
      n_retry    = '0;
      back       = '0;
      rem        = '0;
      bytes_nx   = '0;
      frame_last = 1'b0;

      phase_in   = phase_ff;
      error_in   = error_ff;
      target_in  = target_ff;
      size_in    = size_ff;
      bytes_in   = bytes_ff;
      seq_in     = seq_ff;
      bstart_in  = bstart_ff;
      bframes_in = bframes_ff;
      retry_in   = retry_ff;
      elapsed_in = elapsed_ff;
      reply_in   = reply_ff;

      strobe_in = 1'b0;
      act_in    = act_ff;
      off_in    = off_ff;
      valid_in  = valid_ff;
      oseq_in   = oseq_ff;
      otgt_in   = otgt_ff;
      ophase_in = ophase_ff;
      oerr_in   = oerr_ff;
      orep_in   = orep_ff;
      olast_in  = olast_ff;

      status.burst_go   = 1'b0;
      status.burst_last = 1'b0;

      if (cmd.eval_en) begin
         reply_in = REPLY_NO_START;
         if (op_ff == OP_TICK && elapsed_ff < ELAPSED_MAX) begin
            elap_eff = ELAP_W'(elapsed_ff + 1'b1);
         end
         elapsed_in = elap_eff;
         have = (op_ff == OP_RESP) &&
                (target_ff == cfg.bcast_id || rboard_ff == target_ff ||
                 rboard_ff == cfg.bcast_id);

         if (op_ff == OP_START) begin
            if (phase_ff inside {[PH_PREPARE:PH_ACTIVATE]}) begin
               reply_in = REPLY_BUSY;
            end else if (!iready_ff) begin
               error_in = ERR_NOIMG;
               reply_in = REPLY_NOIMG;
            end else begin
               target_in  = board_ff;
               size_in    = isize_ff;
               bytes_in   = '0;
               seq_in     = '0;
               bstart_in  = '0;
               bframes_in = '0;
               retry_in   = '0;
               error_in   = ERR_NONE;
               cmd_act    = ACT_PREPARE;
               phase_in   = PH_PREPARE;
               elapsed_in = '0;
               reply_in   = REPLY_OK;
            end
         end else if (op_ff == OP_ABORT) begin
            cmd_act  = ACT_ABORT;
            phase_in = PH_FAILED;
            error_in = ERR_NAK;
         end else begin
            case (phase_ff)
               PH_PREPARE, PH_HEADER: begin
                  if (have) begin
                     if (code_ff != RESP_ACK) begin
                        phase_in = PH_FAILED;
                        error_in = ERR_NAK;
                     end else if (phase_ff == PH_PREPARE) begin
                        phase_in   = PH_HEADER;
                        cmd_act    = ACT_HEADER;
                        elapsed_in = '0;
                     end else begin
                        phase_in   = PH_DATA;
                        elapsed_in = '0;
                        want_burst = 1'b1;
                     end
                  end else if (elap_eff > ELAP_W'(cfg.prepare_tmo)) begin
                     phase_in = PH_FAILED;
                     error_in = ERR_TMO;
                  end
               end
               PH_DATA: begin
                  if (have) begin
                     if (code_ff != RESP_ACK) begin
                        phase_in = PH_FAILED;
                        error_in = ERR_NAK;
                     end else begin
                        retry_in   = '0;
                        elapsed_in = '0;
                        if (bytes_ff >= BYTES_W'(size_ff)) begin
                           phase_in = PH_VERIFY;
                           cmd_act  = ACT_VERIFY;
                        end else begin
                           want_burst = 1'b1;
                        end
                     end
                  end else if (elap_eff > ELAP_W'(cfg.burst_tmo)) begin
                     n_retry = (RETRY_W+1)'(retry_ff) + 1'b1;
                     if (n_retry > (RETRY_W+1)'(cfg.retry_limit)) begin
                        retry_in = n_retry[RETRY_W] ? RETRY_SAT : n_retry[RETRY_W-1:0];
                        phase_in = PH_FAILED;
                        error_in = ERR_RETRY;
                     end else begin
                        back = (bframes_ff != '0) ?
                               BYTES_W'(BYTES_W'(bframes_ff) * PAY_B) : BACK_FULL;
                        if (back > bytes_ff) begin
                           back = bytes_ff;
                        end
                        retry_in   = n_retry[RETRY_W-1:0];
                        bytes_in   = bytes_ff - back;
                        seq_in     = bstart_ff;
                        elapsed_in = '0;
                        want_burst = 1'b1;
                     end
                  end
               end
               PH_VERIFY: begin
                  if (have) begin
                     if (code_ff == RESP_VERIFY) begin
                        cmd_act    = ACT_ACTIVATE;
                        phase_in   = PH_ACTIVATE;
                        elapsed_in = '0;
                     end else begin
                        phase_in = PH_FAILED;
                        error_in = ERR_VERIFY;
                     end
                  end else if (elap_eff > ELAP_W'(cfg.verify_tmo)) begin
                     phase_in = PH_FAILED;
                     error_in = ERR_TMO;
                  end
               end
               PH_ACTIVATE: begin
                  if (have && code_ff == RESP_BOOT_OK) begin
                     phase_in = PH_DONE;
                     error_in = ERR_NONE;
                  end else if (elap_eff > ELAP_W'(cfg.boot_tmo)) begin
                     phase_in = PH_FAILED;
                     error_in = ERR_TMO;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end

         if (want_burst) begin
            bstart_in  = seq_in;
            bframes_in = '0;
         end
         status.burst_go = want_burst && (bytes_in < BYTES_W'(size_in));

         if (!status.burst_go) begin
            strobe_in = 1'b1;
            act_in    = cmd_act;
            off_in    = '0;
            valid_in  = '0;
            oseq_in   = (cmd_act == ACT_NONE) ? '0 : seq_in;
            olast_in  = 1'b1;
         end
         otgt_in   = (phase_in == PH_IDLE) ? ID_NONE : target_in;
         ophase_in = phase_in;
         oerr_in   = error_in;
         orep_in   = reply_in;
      end else if (cmd.burst_en) begin
         rem        = BYTES_W'(size_ff) - bytes_ff;
         bytes_nx   = bytes_ff + PAY_B;
         frame_last = (bframes_ff == FRAMES_W'(BURST - 1)) ||
                      (bytes_nx >= BYTES_W'(size_ff));
         status.burst_last = frame_last;

         bytes_in   = bytes_nx;
         seq_in     = SEQ_W'(seq_ff + 1'b1);
         bframes_in = FRAMES_W'(bframes_ff + 1'b1);

         strobe_in = 1'b1;
         act_in    = ACT_DATA;
         off_in    = bytes_ff[SIZE_W-1:0];
         valid_in  = (rem < PAY_B) ? rem[VALID_W-1:0] : VALID_W'(PAYLOAD);
         oseq_in   = seq_ff;
         otgt_in   = (phase_ff == PH_IDLE) ? ID_NONE : target_ff;
         ophase_in = phase_ff;
         oerr_in   = error_ff;
         orep_in   = reply_ff;
         olast_in  = frame_last;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_en) begin
         op_ff     <= req_op;
         board_ff  <= req_board_id;
         isize_ff  <= req_image_size;
         iready_ff <= req_image_ready;
         code_ff   <= req_resp_code;
         rboard_ff <= req_resp_board;
      end
      act_ff    <= act_in;
      off_ff    <= off_in;
      valid_ff  <= valid_in;
      oseq_ff   <= oseq_in;
      otgt_ff   <= otgt_in;
      ophase_ff <= ophase_in;
      oerr_ff   <= oerr_in;
      orep_ff   <= orep_in;
      olast_ff  <= olast_in;
      reply_ff  <= reply_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         error_ff   <= ERR_NONE;
         target_ff  <= ID_NONE;
         size_ff    <= '0;
         bytes_ff   <= '0;
         seq_ff     <= '0;
         bstart_ff  <= '0;
         bframes_ff <= '0;
         retry_ff   <= '0;
         elapsed_ff <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         error_ff   <= error_in;
         target_ff  <= target_in;
         size_ff    <= size_in;
         bytes_ff   <= bytes_in;
         seq_ff     <= seq_in;
         bstart_ff  <= bstart_in;
         bframes_ff <= bframes_in;
         retry_ff   <= retry_in;
         elapsed_ff <= elapsed_in;
         strobe_ff  <= strobe_in;
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_action       = act_ff;
   assign rsp_frame_offset = off_ff;
   assign rsp_valid_bytes  = valid_ff;
   assign rsp_frame_seq    = oseq_ff;
   assign rsp_target       = otgt_ff;
   assign rsp_phase        = ophase_ff;
   assign rsp_error_code   = oerr_ff;
   assign rsp_start_reply  = orep_ff;
   assign rsp_last         = olast_ff;

endmodule

/* hdl/firmware_push_burst_ack_master_top.sv */
// Top level of the image push master: configuration registers, controller
// and datapath. Depends on fpb_pkg, fpb_csr, fpb_ctrl and fpb_dp.
//
// A transaction (start, abort, response or one-millisecond tick) is accepted
// when start is high and busy is low. Each transaction yields one or more
// results on consecutive cycles, each marked by rsp_strobe for exactly one
// cycle and with rsp_last on the final one; the receiver cannot stall them.
// A transaction's request is registered on acceptance, evaluated in the EVAL
// state, and each result is registered before it shows; one that starts or
// resends a data burst of up to BURST frames then enters the burst sequencer,
// which issues one frame per cycle. Busy drops in the cycle that shows the final
// result, so the next transaction can be accepted then.
module firmware_push_burst_ack_master_top
   import fpb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_op,
   input  logic [ID_W-1:0]    req_board_id,
   input  logic [SIZE_W-1:0]  req_image_size,
   input  logic               req_image_ready,
   input  logic [1:0]         req_resp_code,
   input  logic [ID_W-1:0]    req_resp_board,
   output logic               rsp_strobe,
   output logic [2:0]         rsp_action,
   output logic [SIZE_W-1:0]  rsp_frame_offset,
   output logic [VALID_W-1:0] rsp_valid_bytes,
   output logic [SEQ_W-1:0]   rsp_frame_seq,
   output logic [ID_W-1:0]    rsp_target,
   output logic [2:0]         rsp_phase,
   output logic [2:0]         rsp_error_code,
   output logic [1:0]         rsp_start_reply,
   output logic               rsp_last,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [ADDR_W-1:0]  paddr,
   input  logic [DATA_W-1:0]  pwdata,
   output logic [DATA_W-1:0]  prdata,
   output logic               pready
);

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   fpb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   fpb_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   fpb_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .cfg              (cfg),
      .req_op           (req_op),
      .req_board_id     (req_board_id),
      .req_image_size   (req_image_size),
      .req_image_ready  (req_image_ready),
      .req_resp_code    (req_resp_code),
      .req_resp_board   (req_resp_board),
      .rsp_strobe       (rsp_strobe),
      .rsp_action       (rsp_action),
      .rsp_frame_offset (rsp_frame_offset),
      .rsp_valid_bytes  (rsp_valid_bytes),
      .rsp_frame_seq    (rsp_frame_seq),
      .rsp_target       (rsp_target),
      .rsp_phase        (rsp_phase),
      .rsp_error_code   (rsp_error_code),
      .rsp_start_reply  (rsp_start_reply),
      .rsp_last         (rsp_last)
   );

endmodule

/* hdl/fpb_checker.sv */
// Port-level checker of the image push master and its bind to the top level.
// Depends on fpb_pkg and firmware_push_burst_ack_master_top_macros.svh.
`include "firmware_push_burst_ack_master_top_macros.svh"

module fpb_checker
   import fpb_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            start,
   input logic            busy,
   input logic            rsp_strobe,
   input logic [2:0]      rsp_action,
   input logic [ID_W-1:0] rsp_target,
   input logic [2:0]      rsp_phase,
   input logic            rsp_last
);

   `FPB_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy)
   `FPB_ASSERT_NXT(a_burst_contig, clock, reset, rsp_strobe && !rsp_last, rsp_strobe)
   `FPB_ASSERT_IMP(a_last_idle, clock, reset, rsp_strobe && rsp_last, !busy)
   `FPB_ASSERT_IMP(a_none_last, clock, reset, rsp_strobe && rsp_action == ACT_NONE, rsp_last)
   `FPB_ASSERT_IMP(a_idle_tgt, clock, reset, rsp_strobe && rsp_phase == PH_IDLE, rsp_target == ID_NONE)

endmodule

bind firmware_push_burst_ack_master_top fpb_checker u_fpb_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_action (rsp_action),
   .rsp_target (rsp_target),
   .rsp_phase  (rsp_phase),
   .rsp_last   (rsp_last)
);

/* tb/tb_firmware_push_burst_ack_master_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the image push master: directed table, then random sessions.
// Carries its own predictor of phases, bursts and timeouts; depends on fpb_pkg and the top.
module tb_firmware_push_burst_ack_master_top;
   import fpb_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASES         = 5;
   localparam int ITEMS_PER_PHASE = 40;

   typedef struct packed {
      logic [1:0]        op;
      logic [ID_W-1:0]   board;
      logic [SIZE_W-1:0] size;
      logic              ready;
      logic [1:0]        code;
      logic [ID_W-1:0]   rboard;
   } push_event_type;

   typedef struct packed {
      logic [2:0]         action;
      logic [SIZE_W-1:0]  offset;
      logic [VALID_W-1:0] nbytes;
      logic [SEQ_W-1:0]   seq;
      logic [ID_W-1:0]    target;
      logic [2:0]         phase;
      logic [2:0]         err;
      logic [1:0]         reply;
      logic               last;
   } cmd_result_type;

   typedef struct packed {
      push_event_type ev;
      logic           typed;
      cmd_result_type want;
   } directed_row_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_op;
   logic [ID_W-1:0]    req_board_id;
   logic [SIZE_W-1:0]  req_image_size;
   logic               req_image_ready;
   logic [1:0]         req_resp_code;
   logic [ID_W-1:0]    req_resp_board;
   logic               rsp_strobe;
   logic [2:0]         rsp_action;
   logic [SIZE_W-1:0]  rsp_frame_offset;
   logic [VALID_W-1:0] rsp_valid_bytes;
   logic [SEQ_W-1:0]   rsp_frame_seq;
   logic [ID_W-1:0]    rsp_target;
   logic [2:0]         rsp_phase;
   logic [2:0]         rsp_error_code;
   logic [1:0]         rsp_start_reply;
   logic               rsp_last;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [ADDR_W-1:0]  paddr;
   logic [DATA_W-1:0]  pwdata;
   logic [DATA_W-1:0]  prdata;
   logic               pready;

   cfg_type           cfg_copy;
   logic [2:0]        ps_phase;
   logic [2:0]        ps_err;
   logic [ID_W-1:0]   ps_target;
   logic [SIZE_W-1:0] ps_size;
   logic [BYTES_W-1:0] ps_sent;
   logic [SEQ_W-1:0]  ps_seq;
   logic [SEQ_W-1:0]  ps_burst_seq;
   int                ps_burst_len;
   logic [RETRY_W-1:0] ps_retries;
   logic [ELAP_W-1:0] ps_elapsed;

   cmd_result_type   step_cmds[$];
   cmd_result_type   expected_cmds[$];
   directed_row_type directed_rows[$];
   int               mismatch_count = 0;
   int               quiet_cycles = 0;
   bit               steady_stretch = 1'b0;

   firmware_push_burst_ack_master_top dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_op           (req_op),
      .req_board_id     (req_board_id),
      .req_image_size   (req_image_size),
      .req_image_ready  (req_image_ready),
      .req_resp_code    (req_resp_code),
      .req_resp_board   (req_resp_board),
      .rsp_strobe       (rsp_strobe),
      .rsp_action       (rsp_action),
      .rsp_frame_offset (rsp_frame_offset),
      .rsp_valid_bytes  (rsp_valid_bytes),
      .rsp_frame_seq    (rsp_frame_seq),
      .rsp_target       (rsp_target),
      .rsp_phase        (rsp_phase),
      .rsp_error_code   (rsp_error_code),
      .rsp_start_reply  (rsp_start_reply),
      .rsp_last         (rsp_last),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("%0t mismatch: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want_val);
      if (got !== want_val) begin
         report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want_val));
      end
   endtask

   always @(posedge clock) begin : result_check
      cmd_result_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_cmds.size() == 0) begin
            report_mismatch("result with no transaction outstanding");
         end else begin
            want = expected_cmds.pop_front();
            check_field("action", 32'(rsp_action), 32'(want.action));
            check_field("frame_offset", 32'(rsp_frame_offset), 32'(want.offset));
            check_field("valid_bytes", 32'(rsp_valid_bytes), 32'(want.nbytes));
            check_field("frame_seq", 32'(rsp_frame_seq), 32'(want.seq));
            check_field("target", 32'(rsp_target), 32'(want.target));
            check_field("phase", 32'(rsp_phase), 32'(want.phase));
            check_field("error_code", 32'(rsp_error_code), 32'(want.err));
            check_field("start_reply", 32'(rsp_start_reply), 32'(want.reply));
            check_field("last", 32'(rsp_last), 32'(want.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_strobe === 1'b1) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_firmware_push_burst_ack_master_top: FAIL");
         $finish;
      end
   end

   function automatic void push_cmd(input logic [2:0] act, input logic [SIZE_W-1:0] off,
                                    input logic [VALID_W-1:0] nbytes,
                                    input logic [SEQ_W-1:0] seq);
      cmd_result_type r;
      r = '0;
      r.action = act;
      r.offset = off;
      r.nbytes = nbytes;
      r.seq = seq;
      step_cmds.push_back(r);
   endfunction

   function automatic void enter_failed(input logic [2:0] err);
      ps_phase = PH_FAILED;
      ps_err = err;
   endfunction

   function automatic void send_frames();
      logic [BYTES_W-1:0] left;
      ps_burst_seq = ps_seq;
      ps_burst_len = 0;
      while (ps_burst_len < BURST && ps_sent < {1'b0, ps_size}) begin
         left = {1'b0, ps_size} - ps_sent;
         push_cmd(ACT_DATA, ps_sent[SIZE_W-1:0],
                  (left < PAYLOAD) ? VALID_W'(left) : VALID_W'(PAYLOAD), ps_seq);
         ps_sent = ps_sent + BYTES_W'(PAYLOAD);
         ps_seq = ps_seq + 1'b1;
         ps_burst_len++;
      end
   endfunction

   function automatic void advance_phase(input bit have, input logic [1:0] code);
      int unsigned tries;
      int unsigned back;
      case (ps_phase)
         PH_PREPARE, PH_HEADER: begin
            if (have) begin
               if (code != RESP_ACK) begin
                  enter_failed(ERR_NAK);
               end else if (ps_phase == PH_PREPARE) begin
                  ps_phase = PH_HEADER;
                  push_cmd(ACT_HEADER, '0, '0, ps_seq);
                  ps_elapsed = '0;
               end else begin
                  ps_phase = PH_DATA;
                  ps_elapsed = '0;
                  send_frames();
               end
            end else if (ps_elapsed > cfg_copy.prepare_tmo) begin
               enter_failed(ERR_TMO);
            end
         end
         PH_DATA: begin
            if (have) begin
               if (code != RESP_ACK) begin
                  enter_failed(ERR_NAK);
               end else begin
                  ps_retries = '0;
                  ps_elapsed = '0;
                  if (ps_sent >= {1'b0, ps_size}) begin
                     ps_phase = PH_VERIFY;
                     push_cmd(ACT_VERIFY, '0, '0, ps_seq);
                  end else begin
                     send_frames();
                  end
               end
            end else if (ps_elapsed > cfg_copy.burst_tmo) begin
               tries = ps_retries + 1;
               if (tries > cfg_copy.retry_limit) begin
                  ps_retries = (tries > 15) ? RETRY_SAT : RETRY_W'(tries);
                  enter_failed(ERR_RETRY);
               end else begin
                  back = (ps_burst_len > 0) ? ps_burst_len * PAYLOAD : BURST * PAYLOAD;
                  ps_retries = RETRY_W'(tries);
                  if (back > ps_sent) begin
                     back = ps_sent;
                  end
                  ps_sent = ps_sent - BYTES_W'(back);
                  ps_seq = ps_burst_seq;
                  ps_elapsed = '0;
                  send_frames();
               end
            end
         end
         PH_VERIFY: begin
            if (have) begin
               if (code == RESP_VERIFY) begin
                  push_cmd(ACT_ACTIVATE, '0, '0, ps_seq);
                  ps_phase = PH_ACTIVATE;
                  ps_elapsed = '0;
               end else begin
                  enter_failed(ERR_VERIFY);
               end
            end else if (ps_elapsed > cfg_copy.verify_tmo) begin
               enter_failed(ERR_TMO);
            end
         end
         PH_ACTIVATE: begin
            if (have && code == RESP_BOOT_OK) begin
               ps_phase = PH_DONE;
               ps_err = ERR_NONE;
            end else if (ps_elapsed > cfg_copy.boot_tmo) begin
               enter_failed(ERR_TMO);
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void predict_event(input push_event_type ev);
      logic [1:0] reply;
      bit         keep;
      reply = REPLY_NO_START;
      step_cmds.delete();
      case (ev.op)
         OP_START: begin
            if (ps_phase != PH_IDLE && ps_phase != PH_DONE && ps_phase != PH_FAILED) begin
               reply = REPLY_BUSY;
            end else if (!ev.ready) begin
               ps_err = ERR_NOIMG;
               reply = REPLY_NOIMG;
            end else begin
               ps_target = ev.board;
               ps_size = ev.size;
               ps_sent = '0;
               ps_seq = '0;
               ps_burst_seq = '0;
               ps_burst_len = 0;
               ps_retries = '0;
               ps_err = ERR_NONE;
               push_cmd(ACT_PREPARE, '0, '0, ps_seq);
               ps_phase = PH_PREPARE;
               ps_elapsed = '0;
               reply = REPLY_OK;
            end
         end
         OP_ABORT: begin
            push_cmd(ACT_ABORT, '0, '0, ps_seq);
            enter_failed(ERR_NAK);
         end
         OP_RESP: begin
            keep = ps_target == cfg_copy.bcast_id || ev.rboard == ps_target ||
                   ev.rboard == cfg_copy.bcast_id;
            advance_phase(keep, ev.code);
         end
         default: begin
            if (ps_elapsed != ELAPSED_MAX) begin
               ps_elapsed = ps_elapsed + 1'b1;
            end
            advance_phase(1'b0, RESP_ACK);
         end
      endcase
      if (step_cmds.size() == 0) begin
         push_cmd(ACT_NONE, '0, '0, '0);
      end
      foreach (step_cmds[k]) begin
         step_cmds[k].target = (ps_phase == PH_IDLE) ? ID_NONE : ps_target;
         step_cmds[k].phase = ps_phase;
         step_cmds[k].err = ps_err;
         step_cmds[k].reply = reply;
         step_cmds[k].last = (k == step_cmds.size() - 1);
      end
   endfunction

   function automatic push_event_type make_event(input logic [1:0] op,
                                                 input logic [ID_W-1:0] board,
                                                 input logic [SIZE_W-1:0] size,
                                                 input logic ready, input logic [1:0] code,
                                                 input logic [ID_W-1:0] rboard);
      push_event_type ev;
      ev.op = op;
      ev.board = board;
      ev.size = size;
      ev.ready = ready;
      ev.code = code;
      ev.rboard = rboard;
      return ev;
   endfunction

   function automatic void add_row(input push_event_type ev);
      directed_row_type row;
      row = '0;
      row.ev = ev;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_checked_row(input push_event_type ev, input logic [2:0] act,
                                           input logic [ID_W-1:0] tgt, input logic [2:0] ph,
                                           input logic [2:0] err, input logic [1:0] reply);
      directed_row_type row;
      row = '0;
      row.ev = ev;
      row.typed = 1'b1;
      row.want.action = act;
      row.want.target = tgt;
      row.want.phase = ph;
      row.want.err = err;
      row.want.reply = reply;
      row.want.last = 1'b1;
      directed_rows.push_back(row);
   endfunction

   function automatic push_event_type next_event();
      push_event_type ev;
      int roll;
      int pick;
      ev.op = OP_TICK;
      ev.board = ID_W'($urandom);
      ev.size = SIZE_W'($urandom);
      ev.ready = 1'b1;
      ev.code = 2'($urandom);
      ev.rboard = ID_W'($urandom);
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         ev.op = OP_ABORT;
      end else if (ps_phase == PH_IDLE || ps_phase == PH_DONE || ps_phase == PH_FAILED) begin
         if (roll < 75) begin
            ev.op = OP_START;
            ev.ready = ($urandom_range(0, 9) != 0);
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
               ev.size = '0;
            end else if (pick < 6) begin
               ev.size = SIZE_W'($urandom_range(1, 3 * BURST) * PAYLOAD);
            end else if (pick > 6) begin
               ev.size = SIZE_W'($urandom_range(1, 3 * BURST * PAYLOAD));
            end
         end else if (roll < 88) begin
            ev.op = OP_TICK;
         end else begin
            ev.op = OP_RESP;
         end
      end else if (roll < 8) begin
         ev.op = OP_START;
      end else if (roll < 40) begin
         ev.op = OP_TICK;
      end else begin
         ev.op = OP_RESP;
         pick = $urandom_range(0, 9);
         if (pick < 8) begin
            ev.rboard = ps_target;
         end else if (pick == 8) begin
            ev.rboard = cfg_copy.bcast_id;
         end
         pick = $urandom_range(0, 9);
         case (ps_phase)
            PH_VERIFY: if (pick < 8) ev.code = RESP_VERIFY;
            PH_ACTIVATE: if (pick < 7) ev.code = RESP_BOOT_OK;
            default: if (pick < 9) ev.code = RESP_ACK;
         endcase
      end
      return ev;
   endfunction

   task automatic drive_event(input push_event_type ev, input logic typed,
                              input cmd_result_type want);
      int gap;
      int roll;
      start <= 1'b1;
      req_op <= ev.op;
      req_board_id <= ev.board;
      req_image_size <= ev.size;
      req_image_ready <= ev.ready;
      req_resp_code <= ev.code;
      req_resp_board <= ev.rboard;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      predict_event(ev);
      if (typed) begin
         expected_cmds.push_back(want);
      end else begin
         foreach (step_cmds[k]) expected_cmds.push_back(step_cmds[k]);
      end
      roll = $urandom_range(0, 99);
      if (steady_stretch || roll < 55) begin
         gap = 0;
      end else if (roll < 90) begin
         gap = $urandom_range(1, 4);
      end else begin
         gap = $urandom_range(10, 40);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (expected_cmds.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      case (idx)
         REG_PREPARE_TMO: cfg_copy.prepare_tmo = value[TMO_W-1:0];
         REG_BURST_TMO:   cfg_copy.burst_tmo = value[TMO_W-1:0];
         REG_VERIFY_TMO:  cfg_copy.verify_tmo = value[TMO_W-1:0];
         REG_BOOT_TMO:    cfg_copy.boot_tmo = value[TMO_W-1:0];
         REG_RETRY_LIMIT: cfg_copy.retry_limit = value[RETRY_W-1:0];
         REG_BCAST_ID:    cfg_copy.bcast_id = value[ID_W-1:0];
         default: begin
         end
      endcase
   endtask

   task automatic load_settings(input int setting);
      logic [DATA_W-1:0] prep_v, burst_v, verify_v, boot_v, retry_v, bcast_v;
      case (setting)
         0: begin
            prep_v = '0;
            burst_v = '0;
            verify_v = '0;
            boot_v = '0;
            retry_v = '0;
            bcast_v = '0;
         end
         1: begin
            prep_v = 32'hFFFF;
            burst_v = 32'hFFFF;
            verify_v = 32'hFFFF;
            boot_v = 32'hFFFF;
            retry_v = 32'd15;
            bcast_v = 32'd255;
         end
         default: begin
            prep_v = $urandom_range(0, 3);
            burst_v = $urandom_range(0, 2);
            verify_v = $urandom_range(0, 3);
            boot_v = $urandom_range(0, 3);
            retry_v = $urandom_range(0, 15);
            bcast_v = $urandom_range(0, 255);
         end
      endcase
      write_reg(REG_PREPARE_TMO, prep_v);
      write_reg(REG_BURST_TMO, burst_v);
      write_reg(REG_VERIFY_TMO, verify_v);
      write_reg(REG_BOOT_TMO, boot_v);
      write_reg(REG_RETRY_LIMIT, retry_v);
      write_reg(REG_BCAST_ID, bcast_v);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   initial begin
      cmd_result_type no_want;
      reset = 1'b1;
      start = 1'b0;
      req_op = OP_TICK;
      req_board_id = '0;
      req_image_size = '0;
      req_image_ready = 1'b0;
      req_resp_code = RESP_ACK;
      req_resp_board = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      no_want = '0;

      cfg_copy.prepare_tmo = PREPARE_TMO_RST;
      cfg_copy.burst_tmo = BURST_TMO_RST;
      cfg_copy.verify_tmo = VERIFY_TMO_RST;
      cfg_copy.boot_tmo = BOOT_TMO_RST;
      cfg_copy.retry_limit = RETRY_LIMIT_RST;
      cfg_copy.bcast_id = BCAST_ID_RST;
      ps_phase = PH_IDLE;
      ps_err = ERR_NONE;
      ps_target = ID_NONE;
      ps_size = '0;
      ps_sent = '0;
      ps_seq = '0;
      ps_burst_seq = '0;
      ps_burst_len = 0;
      ps_retries = '0;
      ps_elapsed = '0;

      add_checked_row(make_event(OP_TICK, 8'h00, '0, 1'b0, RESP_ACK, 8'h00),
                      ACT_NONE, ID_NONE, PH_IDLE, ERR_NONE, REPLY_NO_START);
      add_checked_row(make_event(OP_RESP, 8'h00, '0, 1'b0, RESP_ACK, 8'h3C),
                      ACT_NONE, ID_NONE, PH_IDLE, ERR_NONE, REPLY_NO_START);
      add_checked_row(make_event(OP_START, 8'h5A, 20'd100, 1'b0, RESP_ACK, 8'h00),
                      ACT_NONE, ID_NONE, PH_IDLE, ERR_NOIMG, REPLY_NOIMG);
      add_checked_row(make_event(OP_ABORT, 8'h00, '0, 1'b0, RESP_ACK, 8'h00),
                      ACT_ABORT, ID_NONE, PH_FAILED, ERR_NAK, REPLY_NO_START);
      add_checked_row(make_event(OP_START, 8'h5A, 20'd200, 1'b1, RESP_ACK, 8'h00),
                      ACT_PREPARE, 8'h5A, PH_PREPARE, ERR_NONE, REPLY_OK);
      add_checked_row(make_event(OP_START, 8'hA5, 20'd64, 1'b1, RESP_ACK, 8'h00),
                      ACT_NONE, 8'h5A, PH_PREPARE, ERR_NONE, REPLY_BUSY);
      add_row(make_event(OP_RESP, 8'h00, '0, 1'b0, RESP_ACK, 8'h11));
      add_row(make_event(OP_RESP, 8'h00, '0, 1'b0, RESP_ACK, 8'hFF));
      add_row(make_event(OP_TICK, 8'h00, '0, 1'b0, RESP_ACK, 8'h00));
      add_row(make_event(OP_RESP, 8'h00, '0, 1'b0, RESP_ACK, 8'h5A));
      add_row(make_event(OP_RESP, 8'h00, '0, 1'b0, RESP_ACK, 8'h5A));
      add_checked_row(make_event(OP_RESP, 8'h00, '0, 1'b0, 2'd3, 8'h5A),
                      ACT_NONE, 8'h5A, PH_FAILED, ERR_VERIFY, REPLY_NO_START);
      add_row(make_event(OP_START, 8'h00, 20'd0, 1'b1, RESP_ACK, 8'h00));
      add_row(make_event(OP_RESP, 8'h00, '0, 1'b0, RESP_ACK, 8'h00));
      add_row(make_event(OP_RESP, 8'h00, '0, 1'b0, RESP_ACK, 8'h00));
      add_row(make_event(OP_RESP, 8'h00, '0, 1'b0, RESP_ACK, 8'h00));
      add_row(make_event(OP_RESP, 8'h00, '0, 1'b0, RESP_VERIFY, 8'h00));
      add_row(make_event(OP_RESP, 8'h00, '0, 1'b0, RESP_ACK, 8'h00));
      add_row(make_event(OP_RESP, 8'h00, '0, 1'b0, RESP_BOOT_OK, 8'h00));
      add_row(make_event(OP_START, 8'hFF, 20'hFFFFF, 1'b1, RESP_ACK, 8'h00));
      add_checked_row(make_event(OP_RESP, 8'h00, '0, 1'b0, 2'd3, 8'h00),
                      ACT_NONE, 8'hFF, PH_FAILED, ERR_NAK, REPLY_NO_START);
      add_row(make_event(OP_START, 8'hA5, 20'hFFFFF, 1'b1, RESP_ACK, 8'h00));
      add_row(make_event(OP_RESP, 8'h00, '0, 1'b0, RESP_ACK, 8'hA5));
      add_row(make_event(OP_RESP, 8'h00, '0, 1'b0, RESP_ACK, 8'hA5));
      add_row(make_event(OP_ABORT, 8'h00, '0, 1'b0, RESP_ACK, 8'h00));

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         drive_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);
      end

      for (int p = 0; p < PHASES; p++) begin
         drain();
         load_settings(p);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            if (i % 16 == 0) begin
               steady_stretch = ($urandom_range(0, 3) == 0);
            end
            drive_event(next_event(), 1'b0, no_want);
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_firmware_push_burst_ack_master_top: PASS");
      end else begin
         $display("tb_firmware_push_burst_ack_master_top: FAIL");
      end
      $finish;
   end

endmodule
